>>> hdl/tcap_pkg.sv
// Shared types and constants for the axis command parser.
// ASCII codes and the result struct; no dependencies.
package tcap_pkg;

  localparam logic [7:0] AscUpA  = 8'h41;
  localparam logic [7:0] AscUpD  = 8'h44;
  localparam logic [7:0] AscUpZ  = 8'h5A;
  localparam logic [7:0] AscUpI  = 8'h49;
  localparam logic [7:0] AscLoI  = 8'h69;
  localparam logic [7:0] AscZero = 8'h30;
  localparam logic [7:0] AscNine = 8'h39;
  localparam logic [7:0] AscCr   = 8'h0D;
  localparam logic [7:0] AscLf   = 8'h0A;

  localparam int unsigned FracBits = 16;
  localparam int unsigned IvalOutBits = 24;

  typedef struct packed {
    logic [4:0]             letter;
    logic [3:0]             channel;
    logic [FracBits-1:0]    frac;
    logic [IvalOutBits-1:0] interval;
  } res_t;

endpackage

>>> hdl/tcap_parse_core.sv
// Parser state and per-word next-state logic for the axis command parser.
// Depends on tcap_pkg.
module tcap_parse_core import tcap_pkg::*; #(
  parameter int unsigned LINE_LIMIT    = 255,
  parameter int unsigned VALUE_DIGITS  = 5,
  parameter int unsigned INTERVAL_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       emit_o,
  output res_t       res_o
);

  // guard bits so that per-digit rounded-up weights never carry into the
  // next result code: 2^GB > 9 * n * 10^n
  localparam int unsigned GB  = $clog2(64'd9 * VALUE_DIGITS * (64'd10 ** VALUE_DIGITS) + 64'd1);
  localparam int unsigned FW  = FracBits + GB;
  localparam int unsigned CW  = $clog2(VALUE_DIGITS + 1);
  localparam int unsigned LCW = $clog2(LINE_LIMIT);
  localparam int unsigned IB  = INTERVAL_BITS;
  localparam int unsigned IXW = IB + IvalOutBits;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LETTER, PH_CHANNEL, PH_VALUE, PH_GOT_I, PH_INTERVAL
  } phase_e;

  // weight of digit position j+1: ceil(2^FW / 10^(j+1))
  logic [FW-1:0] step_tab [VALUE_DIGITS+1];
  for (genvar j = 0; j <= VALUE_DIGITS; j++) begin : g_step
    localparam longint unsigned Pow  = 64'd10 ** (j + 1);
    localparam longint unsigned Num  = 64'd1 << FW;
    localparam logic [FW-1:0]   Step = FW'((Num + Pow - 64'd1) / Pow);
    assign step_tab[j] = Step;
  end

  phase_e         phase_q, phase_d, phase_u;
  logic [4:0]     letter_q, letter_d, letter_u;
  logic [3:0]     chan_q, chan_d, chan_u;
  logic [FW-1:0]  frac_q, frac_d, frac_u;
  logic [CW-1:0]  cnt_q, cnt_d, cnt_u;
  logic [IB-1:0]  ival_q, ival_d, ival_u;
  logic [LCW-1:0] lcnt_q, lcnt_d;

  logic           dig, is_start, line_end, emit_brk;
  logic [3:0]     dval;
  logic [4:0]     start_letter;
  logic [7:0]     ltr_off;
  logic [CW-1:0]  wsel;
  logic [FW-1:0]  wprod;
  logic [IB+3:0]  ival_wide;
  logic [IB-1:0]  ival_sat;
  logic [FW-1:0]  frac_src;
  logic [IB-1:0]  ival_src;
  logic [IXW-1:0] ival_ext;

  assign dig          = (byte_i >= AscZero) && (byte_i <= AscNine);
  assign dval         = 4'(byte_i - AscZero);
  assign is_start     = (byte_i >= AscUpA) && (byte_i <= AscUpZ) && (byte_i != AscUpD);
  assign ltr_off      = byte_i - AscUpA;
  assign start_letter = ltr_off[4:0];
  assign line_end     = (byte_i == AscCr) || (byte_i == AscLf) ||
                        (lcnt_q == LCW'(LINE_LIMIT - 1));

  // one digit weight times the digit value
  assign wsel  = (phase_q == PH_CHANNEL) ? '0 : cnt_q;
  assign wprod = FW'(FW'(dval) * step_tab[wsel]);

  // interval * 10 + d, clamped
  assign ival_wide = (IB+4)'({ival_q, 3'b000}) + (IB+4)'({ival_q, 1'b0}) + (IB+4)'(dval);
  assign ival_sat  = (|ival_wide[IB+3:IB]) ? {IB{1'b1}} : ival_wide[IB-1:0];

  always_comb begin
    phase_u  = phase_q;
    letter_u = letter_q;
    chan_u   = chan_q;
    frac_u   = frac_q;
    cnt_u    = cnt_q;
    ival_u   = ival_q;
    emit_brk = 1'b0;
    unique case (phase_q)
      PH_LETTER: begin
        if (dig) begin
          chan_u  = dval;
          phase_u = PH_CHANNEL;
        end else begin
          phase_u = is_start ? PH_LETTER : PH_IDLE;
          if (is_start) letter_u = start_letter;
        end
      end
      PH_CHANNEL: begin
        if (dig) begin
          frac_u  = wprod;
          cnt_u   = CW'(1);
          ival_u  = '0;
          phase_u = PH_VALUE;
        end else begin
          phase_u = is_start ? PH_LETTER : PH_IDLE;
          if (is_start) letter_u = start_letter;
        end
      end
      PH_VALUE: begin
        if (dig) begin
          if (cnt_q < CW'(VALUE_DIGITS)) begin
            frac_u = frac_q + wprod;
            cnt_u  = cnt_q + CW'(1);
          end
        end else if ((byte_i == AscUpI) || (byte_i == AscLoI)) begin
          ival_u  = '0;
          phase_u = PH_GOT_I;
        end else begin
          emit_brk = 1'b1;
          phase_u  = is_start ? PH_LETTER : PH_IDLE;
          if (is_start) letter_u = start_letter;
        end
      end
      PH_GOT_I, PH_INTERVAL: begin
        if (dig) begin
          ival_u  = ival_sat;
          phase_u = PH_INTERVAL;
        end else begin
          emit_brk = 1'b1;
          phase_u  = is_start ? PH_LETTER : PH_IDLE;
          if (is_start) letter_u = start_letter;
        end
      end
      default: begin
        phase_u = is_start ? PH_LETTER : PH_IDLE;
        if (is_start) letter_u = start_letter;
      end
    endcase
  end

  // a line end flushes a command that already has value digits
  assign emit_o = emit_brk ||
                  (line_end && ((phase_u == PH_VALUE) || (phase_u == PH_GOT_I) ||
                                (phase_u == PH_INTERVAL)));

  // break emits the command as held; line-end flush emits after the update
  assign frac_src = emit_brk ? frac_q : frac_u;
  assign ival_src = emit_brk ? ival_q : ival_u;
  assign ival_ext = IXW'(ival_src);

  assign res_o.letter   = emit_brk ? letter_q : letter_u;
  assign res_o.channel  = emit_brk ? chan_q : chan_u;
  assign res_o.frac     = frac_src[FW-1:GB];
  assign res_o.interval = ival_ext[IvalOutBits-1:0];

  always_comb begin
    if (line_end) begin
      phase_d  = PH_IDLE;
      letter_d = '0;
      chan_d   = '0;
      frac_d   = '0;
      cnt_d    = '0;
      ival_d   = '0;
      lcnt_d   = '0;
    end else begin
      phase_d  = phase_u;
      letter_d = letter_u;
      chan_d   = chan_u;
      frac_d   = frac_u;
      cnt_d    = cnt_u;
      ival_d   = ival_u;
      lcnt_d   = lcnt_q + LCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      letter_q <= '0;
      chan_q   <= '0;
      frac_q   <= '0;
      cnt_q    <= '0;
      ival_q   <= '0;
      lcnt_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      letter_q <= letter_d;
      chan_q   <= chan_d;
      frac_q   <= frac_d;
      cnt_q    <= cnt_d;
      ival_q   <= ival_d;
      lcnt_q   <= lcnt_d;
    end
  end

endmodule

>>> hdl/tcap_out_reg.sv
// Result register with valid/stall handshake toward the consumer.
// Depends on tcap_pkg.
module tcap_out_reg import tcap_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic free_o,
  input  logic stall_i,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) valid_d = 1'b1;
    else if (!stall_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> hdl/tcode_axis_command_parser.sv
// Axis command parser: one serial byte per word in, one parsed command per word out.
// An accepted byte waits in the byte register; its command is loaded into the output
// register as the byte enters the parser; the earliest output handshake is the edge after.
// Throughput: one byte per cycle. The input stalls only while the byte register is
// full and the output register holds a command that the consumer is stalling.
// Reset (rst_ni, async, active low) returns the parser to idle with an empty line.
// Depends on tcap_pkg, tcap_parse_core, tcap_out_reg.
module tcode_axis_command_parser import tcap_pkg::*; #(
  parameter int unsigned LINE_LIMIT    = 255,
  parameter int unsigned VALUE_DIGITS  = 5,
  parameter int unsigned INTERVAL_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  cmd_letter_o,
  output logic [3:0]  channel_num_o,
  output logic [15:0] value_frac_o,
  output logic [23:0] interval_ms_o
);

  // Input stage: one byte register. The byte moves into the parser when the
  // output register can take a possible result (empty, or draining now).
  logic       bval_q, bval_d;
  logic [7:0] byte_q;
  logic       in_acc, step, out_free, emit;
  res_t       res_new, res_out;

  assign step       = bval_q && out_free;
  assign in_stall_o = bval_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    bval_d = bval_q;
    if (in_acc) bval_d = 1'b1;
    else if (step) bval_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bval_q <= 1'b0;
    end else begin
      bval_q <= bval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= in_byte_i;
    end
  end

  // Parse step: letter / channel / value / interval phases, line counting,
  // and the Q0.16 fraction built up digit by digit.
  tcap_parse_core #(
    .LINE_LIMIT   (LINE_LIMIT),
    .VALUE_DIGITS (VALUE_DIGITS),
    .INTERVAL_BITS(INTERVAL_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .emit_o (emit),
    .res_o  (res_new)
  );

  // Result register; holds a command while the consumer stalls.
  tcap_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (step && emit),
    .res_i  (res_new),
    .free_o (out_free),
    .stall_i(out_stall_i),
    .valid_o(out_valid_o),
    .res_o  (res_out)
  );

  assign cmd_letter_o  = res_out.letter;
  assign channel_num_o = res_out.channel;
  assign value_frac_o  = res_out.frac;
  assign interval_ms_o = res_out.interval;

endmodule

>>> tb/tcode_axis_command_parser_tb.sv
// Self-checking testbench for tcode_axis_command_parser: serial bytes in, parsed axis
// commands out, each compared with a parser model kept in this file.
// Depends on tcap_pkg and the tcode_axis_command_parser RTL.
module tcode_axis_command_parser_tb import tcap_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_LIMIT    = 255;
  localparam int unsigned VALUE_DIGITS  = 5;
  localparam int unsigned INTERVAL_BITS = 24;

  // Cycles with no word moving on either side before the run is declared hung.
  // Longest legal quiet stretch comes from the HoldOffCycles output hold-off.
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldOffCycles = 200;

  localparam logic [63:0] IntervalMax = (64'd1 << INTERVAL_BITS) - 64'd1;

  // Parse phases of the command model
  typedef enum logic [2:0] {
    PhIdle, PhLetter, PhChannel, PhValue, PhGotI, PhInterval
  } phase_e;

  // Clock, reset, block ports
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall_o;
  logic [7:0]  in_byte;
  logic        out_valid_o;
  logic        out_stall;
  logic [4:0]  cmd_letter_o;
  logic [3:0]  channel_num_o;
  logic [15:0] value_frac_o;
  logic [23:0] interval_ms_o;

  always #1 clk_i = ~clk_i;

  tcode_axis_command_parser #(
    .LINE_LIMIT   (LINE_LIMIT),
    .VALUE_DIGITS (VALUE_DIGITS),
    .INTERVAL_BITS(INTERVAL_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .cmd_letter_o (cmd_letter_o),
    .channel_num_o(channel_num_o),
    .value_frac_o (value_frac_o),
    .interval_ms_o(interval_ms_o)
  );

  // Commands the parser model says are owed, oldest first
  res_t pending_cmds[$];
  int   n_mismatch = 0;
  int   bytes_sent = 0;

  // Idle controls: random gaps on the byte side, random stalls on the command side,
  // and a one-shot long hold-off request for the command side.
  bit tx_gaps_on = 1'b0;
  bit rx_stalls_on = 1'b0;
  int rx_hold_req = 0;

  // ---------------------------------------------------------------------------
  // Parser model state
  // ---------------------------------------------------------------------------
  phase_e      ph;
  logic [4:0]  cur_letter;
  logic [3:0]  cur_channel;
  logic [16:0] val_acc;
  int unsigned val_ndig;
  logic [23:0] ival_acc;
  int unsigned line_bytes;

  function automatic void clear_parser();
    ph          = PhIdle;
    cur_letter  = '0;
    cur_channel = '0;
    val_acc     = '0;
    val_ndig    = 0;
    ival_acc    = '0;
    line_bytes  = 0;
  endfunction

  // A byte that does not continue the current pattern may open a new command.
  // D is reserved for device commands, which this block does not handle.
  function automatic void restart_on(logic [7:0] b);
    if (b >= AscUpA && b <= AscUpZ && b != AscUpD) begin
      cur_letter = 5'(b - AscUpA);
      ph = PhLetter;
    end else begin
      ph = PhIdle;
    end
  endfunction

  // Value is digits / 10^n as Q0.16, truncated
  function automatic res_t pack_cmd();
    res_t        r;
    logic [63:0] scale;
    scale = 64'd1;
    for (int k = 0; k < val_ndig; k++) scale = scale * 64'd10;
    r.letter   = cur_letter;
    r.channel  = cur_channel;
    r.frac     = 16'(({47'd0, val_acc} << 16) / scale);
    r.interval = ival_acc;
    return r;
  endfunction

  // Advance the model by one byte; returns 1 when the byte completes a command.
  function automatic bit parse_byte(logic [7:0] b, output res_t cmd);
    bit          dig;
    logic [3:0]  d;
    logic [63:0] v;
    bit          hit;
    dig = (b >= AscZero && b <= AscNine);
    d   = dig ? 4'(b - AscZero) : 4'd0;
    hit = 1'b0;
    cmd = '0;
    case (ph)
      PhLetter: begin
        if (dig) begin
          cur_channel = d;
          ph = PhChannel;
        end else begin
          restart_on(b);
        end
      end
      PhChannel: begin
        if (dig) begin
          val_acc  = 17'(d);
          val_ndig = 1;
          ival_acc = '0;
          ph = PhValue;
        end else begin
          restart_on(b);
        end
      end
      PhValue: begin
        if (dig) begin
          // digits past the kept count are swallowed
          if (val_ndig < VALUE_DIGITS) begin
            val_acc  = 17'(val_acc * 10 + d);
            val_ndig = val_ndig + 1;
          end
        end else if (b == AscUpI || b == AscLoI) begin
          ival_acc = '0;
          ph = PhGotI;
        end else begin
          cmd = pack_cmd();
          hit = 1'b1;
          restart_on(b);
        end
      end
      PhGotI, PhInterval: begin
        if (dig) begin
          v = 64'(ival_acc) * 64'd10 + 64'(d);
          ival_acc = (v > IntervalMax) ? 24'(IntervalMax) : 24'(v);
          ph = PhInterval;
        end else begin
          cmd = pack_cmd();
          hit = 1'b1;
          restart_on(b);
        end
      end
      default: restart_on(b);
    endcase

    line_bytes = line_bytes + 1;
    if (b == AscCr || b == AscLf || line_bytes >= LINE_LIMIT) begin
      if (!hit && (ph == PhValue || ph == PhGotI || ph == PhInterval)) begin
        cmd = pack_cmd();
        hit = 1'b1;
      end
      clear_parser();
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte side. Called at a falling edge; returns at the falling edge after the
  // word was taken, leaving valid high so back-to-back words need no re-raise.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    res_t cmd;
    if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (parse_byte(b, cmd)) pending_cmds.push_back(cmd);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] any_digit();
    return 8'(AscZero + $urandom_range(0, 9));
  endfunction

  // One random command: mostly well formed with random content, some broken
  // (letter then junk, letter+channel then junk) and some stray bytes.
  task automatic send_command();
    int          kind;
    int          nval;
    int          nival;
    logic [7:0]  idx;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    idx = 8'($urandom_range(0, 24));
    if (idx >= 8'(AscUpD - AscUpA)) idx++;   // skip D
    send_byte(8'(AscUpA + idx));
    if (kind == 0) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    send_byte(any_digit());
    if (kind == 1) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    // usually within the kept digit count, sometimes past it
    nval = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 5);
    repeat (nval) send_byte(any_digit());
    if ($urandom_range(0, 1)) begin
      send_byte($urandom_range(0, 1) ? AscUpI : AscLoI);
      nival = $urandom_range(0, 9);   // 8+ digits tend to saturate
      repeat (nival) send_byte(any_digit());
    end
    case ($urandom_range(0, 5))
      0:       ;                         // next letter ends it
      1:       send_byte(8'h20);
      2:       send_byte(AscCr);
      3:       send_byte(AscLf);
      4:       send_byte(8'h2C);
      default: send_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  // ---------------------------------------------------------------------------
  // Command side: random stall bursts, or a long hold-off when requested.
  // ---------------------------------------------------------------------------
  initial begin : cmd_sink
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req > 0) begin
        n = rx_hold_req;
        rx_hold_req = 0;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each delivered command with the oldest one owed
  always @(posedge clk_i) begin : check_cmds
    res_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        $error("command with none owed: letter %0d channel %0d frac %0d interval %0d",
               cmd_letter_o, channel_num_o, value_frac_o, interval_ms_o);
        n_mismatch++;
      end else begin
        want = pending_cmds.pop_front();
        if (cmd_letter_o !== want.letter) begin
          $error("cmd_letter: expected %0d, got %0d", want.letter, cmd_letter_o);
          n_mismatch++;
        end
        if (channel_num_o !== want.channel) begin
          $error("channel_num: expected %0d, got %0d", want.channel, channel_num_o);
          n_mismatch++;
        end
        if (value_frac_o !== want.frac) begin
          $error("value_frac: expected %0d, got %0d", want.frac, value_frac_o);
          n_mismatch++;
        end
        if (interval_ms_o !== want.interval) begin
          $error("interval_ms: expected %0d, got %0d", want.interval, interval_ms_o);
          n_mismatch++;
        end
      end
    end
  end

  // Hang detector: cycles with no word moving on either side
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and special cases, no idling
  task automatic test_directed();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    // max letter/channel, extra value digits, interval saturation
    send_text("Z9999999I99999999");
    // A ends Z; I with no digits, then D is ignored and ends A
    send_text("A00i");
    send_byte(AscUpD);
    // letter+channel dropped on a non-ASCII byte
    send_text("B1");
    send_byte(8'hFF);
    // channel without value dropped on NUL
    send_text("C5");
    send_byte(8'h00);
    // pending value emitted at line end
    send_text("Y34");
    send_byte(AscLf);
  endtask

  // Bulk of the run: random commands, idling on both sides
  task automatic test_random_commands(input int target);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    while (bytes_sent < target) send_command();
  endtask

  // Uniform random bytes: any byte value, mostly noise
  task automatic test_noise(input int count);
    tx_gaps_on = 1'b1;
    repeat (count) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Line closed by length alone: the last value digit lands on the limit
  task automatic test_line_limit();
    tx_gaps_on = 1'b0;
    send_byte(AscLf);
    repeat (LINE_LIMIT - 6) send_byte(8'h20);
    send_text("A12345");
    send_text("Q71I5\r");
  endtask

  // Command side holds off while dense commands keep arriving, so the block
  // backs up into its input
  task automatic test_output_holdoff();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    rx_hold_req  = HoldOffCycles;
    repeat (40) begin
      send_byte(8'(AscUpA + $urandom_range(4, 25)));
      send_byte(any_digit());
      send_byte(any_digit());
    end
    send_byte(AscCr);
  endtask

  // Byte side goes quiet until every owed command has come out
  task automatic test_drain_pause();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_cmds.size() != 0);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    repeat (10) send_command();
  endtask

  // Final stretch at full rate on both sides
  task automatic test_full_rate(input int target);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    while (bytes_sent < target) send_command();
  endtask

  initial begin : main
    in_valid = 1'b0;
    in_byte  = '0;
    rst_ni   = 1'b0;
    clear_parser();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_commands(900);
    test_noise(200);
    test_line_limit();
    test_output_holdoff();
    test_drain_pause();
    test_random_commands(1650);
    test_full_rate(1950);

    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
